[design/mvscp_pkg.sv]
// Package for the MPEG video start code prober.
// Holds the shared widths, start code constants, read offsets and the
// command and status structures between the controller and the datapath.
`default_nettype none

package mvscp_pkg;

    // Data and counter widths.
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 32;
    localparam int C9_W       = 9;
    localparam int COUNT_BITS = 20;
    localparam int PROD_W     = COUNT_BITS + 4;
    localparam int SCORE_W    = 7;
    localparam int FLAG_W     = 4;

    // Look-ahead window and its circular byte buffer.
    localparam int WIN_DEPTH  = 139;
    localparam int BUF_DEPTH  = 256;
    localparam int BUF_ADDR_W = $clog2(BUF_DEPTH);
    localparam int AVAIL_W    = $clog2(WIN_DEPTH + 1);
    localparam int OFF_W      = 4;

    localparam logic [BUF_ADDR_W-1:0] BASE_RESET = BUF_ADDR_W'(BUF_DEPTH - WIN_DEPTH);

    // Start code values.
    localparam logic [CODE_W-1:0] CODE_SHIFT_RESET = '1;
    localparam logic [23:0]       START_PREFIX     = 24'h000001;
    localparam logic [CODE_W-1:0] SEQ_HDR_CODE     = 32'h000001B3;
    localparam logic [CODE_W-1:0] PICTURE_CODE     = 32'h00000100;
    localparam logic [CODE_W-1:0] PACK_CODE        = 32'h000001BA;
    localparam logic [CODE_W-1:0] RESERVED_CODE    = 32'h000001B6;
    localparam logic [C9_W-1:0]   SLICE_FIRST      = 9'h101;
    localparam logic [C9_W-1:0]   SLICE_LAST       = 9'h1AF;
    localparam logic [C9_W-1:0]   VIDEO_MASK       = 9'h1F0;
    localparam logic [C9_W-1:0]   VIDEO_PES_BASE   = 9'h1E0;
    localparam logic [C9_W-1:0]   AUDIO_MASK       = 9'h1E0;
    localparam logic [C9_W-1:0]   AUDIO_PES_BASE   = 9'h1C0;

    // Bit positions in the sticky flag register.
    localparam int FLAG_PACK     = 0;
    localparam int FLAG_AUDIO    = 1;
    localparam int FLAG_RESERVED = 2;
    localparam int FLAG_VIDEO    = 3;

    // Sequence header field masks.
    localparam logic [BYTE_W-1:0] MARKER_MASK     = 8'h20;
    localparam logic [BYTE_W-1:0] INTRA_MAT_MASK  = 8'h02;
    localparam logic [BYTE_W-1:0] INTER_MAT_MASK  = 8'h01;
    localparam logic [BYTE_W-1:0] TAIL_LOW_MASK   = 8'hFE;
    localparam logic [AVAIL_W-1:0] MATRIX_STEP    = AVAIL_W'(64);

    // Read offsets relative to the header start plus the matrix skip.
    localparam logic [OFF_W-1:0] OFF_MARKER = 4'd6;
    localparam logic [OFF_W-1:0] OFF_FLAGS  = 4'd7;
    localparam logic [OFF_W-1:0] OFF_TAIL0  = 4'd8;
    localparam logic [OFF_W-1:0] OFF_TAIL1  = 4'd9;
    localparam logic [OFF_W-1:0] OFF_TAIL2  = 4'd10;

    localparam logic [SCORE_W-1:0] EXT_SCORE_RESET = 7'd50;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             accept;
        logic             rd_en;
        logic [OFF_W-1:0] rd_off;
        logic             jp_add;
        logic             jp_clear;
        logic             seq_inc;
        logic             flush_shift;
        logic             prod_load;
        logic             score_load;
        logic             clear;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mark_next;
        logic avail_one;
        logic jp_over;
        logic rd_marker;
        logic rd_intra;
        logic rd_inter;
        logic rd_zero;
        logic rd_low_only;
        logic out_free;
    } dp_status_t;

    // Saturating counter increment.
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (&v) ? v : v + COUNT_BITS'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

[design/mvscp_if.sv]
// Stream interfaces of the MPEG video start code prober.
// Each carries valid, ready and its payload; widths come from mvscp_pkg.
`default_nettype none

interface mvscp_byte_if;
    import mvscp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mvscp_score_if;
    import mvscp_pkg::*;

    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] score;

    modport source (output valid, output score, input ready);
    modport sink   (input valid, input score, output ready);
endinterface

`default_nettype wire

[design/mvscp_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module mvscp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/mvscp_datapath.sv]
// Datapath of the start code prober: start code shift register, counters,
// sticky flags, header mark line, byte buffer RAM and score arithmetic.
// Depends on mvscp_pkg and mvscp_ram.
`default_nettype none

module mvscp_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [mvscp_pkg::SCORE_W-1:0] cfg_wdata,
    input  wire logic [mvscp_pkg::BYTE_W-1:0]  data_byte,
    input  wire mvscp_pkg::ctrl_cmd_t          cmd,
    output mvscp_pkg::dp_status_t              status,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [mvscp_pkg::SCORE_W-1:0]      result_score
);
    import mvscp_pkg::*;

    logic [CODE_W-1:0]     code_shift_reg, code_shift_next;
    logic [C9_W-1:0]       prev_code_reg, prev_code_next;
    logic [COUNT_BITS-1:0] seq_cnt_reg, seq_cnt_next;
    logic [COUNT_BITS-1:0] pic_cnt_reg, pic_cnt_next;
    logic [COUNT_BITS-1:0] ord_cnt_reg, ord_cnt_next;
    logic [COUNT_BITS-1:0] mis_cnt_reg, mis_cnt_next;
    logic [FLAG_W-1:0]     flags_reg, flags_next;
    logic [WIN_DEPTH-1:0]  marks_reg, marks_next;
    logic [BUF_ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [BUF_ADDR_W-1:0] base_reg, base_next;
    logic [AVAIL_W-1:0]    avail_reg, avail_next;
    logic [AVAIL_W-1:0]    jp_reg, jp_next;
    logic                  rd_ok_reg;
    logic [SCORE_W-1:0]    ext_score_reg;
    logic                  out_valid_reg;
    logic [SCORE_W-1:0]    out_score_reg;
    logic [PROD_W-1:0]     seq9_reg, pic10_reg, pic9_reg, ord10_reg;

    logic [CODE_W-1:0]     code_new;
    logic [C9_W-1:0]       c9;
    logic                  is_start;
    logic                  slice_now;
    logic                  slice_prev;
    logic                  slice_up;
    logic                  new_mark;
    logic [AVAIL_W-1:0]    rd_rel;
    logic [BUF_ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0]     ram_q;
    logic [BYTE_W-1:0]     rd_byte;
    logic                  score_ok;
    logic [SCORE_W-1:0]    ext_plus;
    logic [SCORE_W-1:0]    score_val;

    // Start code decode on the incoming byte.
    assign code_new   = {code_shift_reg[CODE_W-BYTE_W-1:0], data_byte};
    assign c9         = code_new[C9_W-1:0];
    assign is_start   = (code_new[CODE_W-1:BYTE_W] == START_PREFIX);
    assign slice_now  = (c9 >= SLICE_FIRST) && (c9 <= SLICE_LAST);
    assign slice_prev = (prev_code_reg >= SLICE_FIRST) && (prev_code_reg <= SLICE_LAST);
    assign slice_up   = slice_prev ? (c9 >= prev_code_reg) : (c9 == SLICE_FIRST);
    assign new_mark   = (code_shift_reg == SEQ_HDR_CODE);

    // Window read address and range check against the bytes present.
    assign rd_rel  = jp_reg + AVAIL_W'(cmd.rd_off);
    assign rd_addr = base_reg + BUF_ADDR_W'(rd_rel);
    assign rd_byte = ram_q & {BYTE_W{rd_ok_reg}};

    mvscp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr (wr_ptr_reg),
        .wdata (data_byte),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Next-state logic for the stream state.
    always_comb
    begin
        code_shift_next = code_shift_reg;
        prev_code_next  = prev_code_reg;
        seq_cnt_next    = seq_cnt_reg;
        pic_cnt_next    = pic_cnt_reg;
        ord_cnt_next    = ord_cnt_reg;
        mis_cnt_next    = mis_cnt_reg;
        flags_next      = flags_reg;
        marks_next      = marks_reg;
        wr_ptr_next     = wr_ptr_reg;
        base_next       = base_reg;
        avail_next      = avail_reg;
        jp_next         = jp_reg;

        if (cmd.accept)
        begin
            code_shift_next = code_new;
            marks_next      = {new_mark, marks_reg[WIN_DEPTH-1:1]};
            wr_ptr_next     = wr_ptr_reg + BUF_ADDR_W'(1);
            base_next       = base_reg + BUF_ADDR_W'(1);
            avail_next      = AVAIL_W'(WIN_DEPTH);
            if (is_start)
            begin
                if (code_new == PICTURE_CODE)
                begin
                    pic_cnt_next = sat_inc(pic_cnt_reg);
                end
                else if (code_new == PACK_CODE)
                begin
                    flags_next[FLAG_PACK] = 1'b1;
                end
                else if (code_new == RESERVED_CODE)
                begin
                    flags_next[FLAG_RESERVED] = 1'b1;
                end
                if (slice_now)
                begin
                    if (slice_up)
                    begin
                        ord_cnt_next = sat_inc(ord_cnt_reg);
                    end
                    else
                    begin
                        mis_cnt_next = sat_inc(mis_cnt_reg);
                    end
                end
                if ((c9 & VIDEO_MASK) == VIDEO_PES_BASE)
                begin
                    flags_next[FLAG_VIDEO] = 1'b1;
                end
                else if ((c9 & AUDIO_MASK) == AUDIO_PES_BASE)
                begin
                    flags_next[FLAG_AUDIO] = 1'b1;
                end
                prev_code_next = c9;
            end
        end

        // Flush walks the mark line with a shrinking window.
        if (cmd.flush_shift)
        begin
            marks_next = {1'b0, marks_reg[WIN_DEPTH-1:1]};
            base_next  = base_reg + BUF_ADDR_W'(1);
            avail_next = avail_reg - AVAIL_W'(1);
        end

        if (cmd.jp_add)
        begin
            jp_next = jp_reg + MATRIX_STEP;
        end
        if (cmd.jp_clear)
        begin
            jp_next = '0;
        end

        if (cmd.seq_inc)
        begin
            seq_cnt_next = sat_inc(seq_cnt_reg);
        end

        if (cmd.clear)
        begin
            code_shift_next = CODE_SHIFT_RESET;
            prev_code_next  = '0;
            seq_cnt_next    = '0;
            pic_cnt_next    = '0;
            ord_cnt_next    = '0;
            mis_cnt_next    = '0;
            flags_next      = '0;
            marks_next      = '0;
            base_next       = wr_ptr_reg - BUF_ADDR_W'(WIN_DEPTH);
            jp_next         = '0;
        end
    end

    // Stream state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_shift_reg <= CODE_SHIFT_RESET;
            prev_code_reg  <= '0;
            seq_cnt_reg    <= '0;
            pic_cnt_reg    <= '0;
            ord_cnt_reg    <= '0;
            mis_cnt_reg    <= '0;
            flags_reg      <= '0;
            marks_reg      <= '0;
            wr_ptr_reg     <= '0;
            base_reg       <= BASE_RESET;
            avail_reg      <= AVAIL_W'(WIN_DEPTH);
            jp_reg         <= '0;
            rd_ok_reg      <= 1'b0;
        end
        else
        begin
            code_shift_reg <= code_shift_next;
            prev_code_reg  <= prev_code_next;
            seq_cnt_reg    <= seq_cnt_next;
            pic_cnt_reg    <= pic_cnt_next;
            ord_cnt_reg    <= ord_cnt_next;
            mis_cnt_reg    <= mis_cnt_next;
            flags_reg      <= flags_next;
            marks_reg      <= marks_next;
            wr_ptr_reg     <= wr_ptr_next;
            base_reg       <= base_next;
            avail_reg      <= avail_next;
            jp_reg         <= jp_next;
            if (cmd.rd_en)
            begin
                rd_ok_reg <= (rd_rel < avail_reg);
            end
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_score_reg <= EXT_SCORE_RESET;
        end
        else if (cfg_we)
        begin
            ext_score_reg <= cfg_wdata;
        end
    end

    // Scaled counts for the ratio tests: times nine and times ten.
    always_ff @(posedge clk)
    begin
        if (cmd.prod_load)
        begin
            seq9_reg  <= PROD_W'({seq_cnt_reg, 3'b000}) + PROD_W'(seq_cnt_reg);
            pic10_reg <= PROD_W'({pic_cnt_reg, 3'b000}) + PROD_W'({pic_cnt_reg, 1'b0});
            pic9_reg  <= PROD_W'({pic_cnt_reg, 3'b000}) + PROD_W'(pic_cnt_reg);
            ord10_reg <= PROD_W'({ord_cnt_reg, 3'b000}) + PROD_W'({ord_cnt_reg, 1'b0});
        end
    end

    // Score from the registered products and the flags.
    always_comb
    begin
        score_ok = (seq_cnt_reg != '0) && (seq9_reg <= pic10_reg) &&
                   (pic9_reg <= ord10_reg) &&
                   !flags_reg[FLAG_PACK] && !flags_reg[FLAG_AUDIO] &&
                   !flags_reg[FLAG_RESERVED] && (ord_cnt_reg > mis_cnt_reg);
        ext_plus = (&ext_score_reg) ? ext_score_reg : ext_score_reg + SCORE_W'(1);
        if (!score_ok)
        begin
            score_val = '0;
        end
        else if (flags_reg[FLAG_VIDEO])
        begin
            score_val = ext_score_reg >> 2;
        end
        else if (pic_cnt_reg > COUNT_BITS'(1))
        begin
            score_val = ext_plus;
        end
        else
        begin
            score_val = ext_score_reg >> 1;
        end
    end

    // Output register holding the score transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.score_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.score_load)
        begin
            out_score_reg <= score_val;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_score = out_score_reg;

    // Status towards the controller.
    always_comb
    begin
        status.mark_next   = marks_reg[1];
        status.avail_one   = (avail_reg == AVAIL_W'(1));
        status.jp_over     = (jp_reg > avail_reg);
        status.rd_marker   = ((rd_byte & MARKER_MASK) != '0);
        status.rd_intra    = ((rd_byte & INTRA_MAT_MASK) != '0);
        status.rd_inter    = ((rd_byte & INTER_MAT_MASK) != '0);
        status.rd_zero     = (rd_byte == '0);
        status.rd_low_only = ((rd_byte & TAIL_LOW_MASK) == '0);
        status.out_free    = !out_valid_reg || result_ready;
    end

endmodule

`default_nettype wire

[design/mvscp_ctrl.sv]
// Controller of the start code prober: byte intake, sequence header
// judging, end-of-buffer flush and score hand-off.
// Depends on mvscp_pkg.
`default_nettype none

module mvscp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_last,
    output logic                      in_ready,
    input  wire mvscp_pkg::dp_status_t status,
    output mvscp_pkg::ctrl_cmd_t      cmd
);
    import mvscp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR,
        ST_MARKER,
        ST_INTRA,
        ST_INTRA_CHK,
        ST_INTER,
        ST_INTER_CHK,
        ST_TAIL0,
        ST_TAIL1,
        ST_TAIL2,
        ST_FLUSH,
        ST_PROD,
        ST_SCORE
    } state_t;

    state_t state_reg, state_next;
    logic   flushing_reg, flushing_next;
    logic   accept;
    state_t judge_exit;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign judge_exit = flushing_reg ? ST_FLUSH : ST_IDLE;

    // Command decode and next state.
    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        flushing_next = flushing_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept    = 1'b1;
                    flushing_next = in_last;
                    if (status.mark_next)
                    begin
                        state_next = ST_HDR;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_HDR:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_off = OFF_MARKER;
                state_next = ST_MARKER;
            end
            ST_MARKER:
            begin
                if (status.rd_marker)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_off = OFF_FLAGS;
                    state_next = ST_INTRA;
                end
                else
                begin
                    cmd.jp_clear = 1'b1;
                    state_next   = judge_exit;
                end
            end
            ST_INTRA:
            begin
                cmd.jp_add = status.rd_intra;
                state_next = ST_INTRA_CHK;
            end
            ST_INTRA_CHK:
            begin
                if (status.jp_over)
                begin
                    cmd.jp_clear = 1'b1;
                    state_next   = judge_exit;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_off = OFF_FLAGS;
                    state_next = ST_INTER;
                end
            end
            ST_INTER:
            begin
                cmd.jp_add = status.rd_inter;
                state_next = ST_INTER_CHK;
            end
            ST_INTER_CHK:
            begin
                if (status.jp_over)
                begin
                    cmd.jp_clear = 1'b1;
                    state_next   = judge_exit;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_off = OFF_TAIL0;
                    state_next = ST_TAIL0;
                end
            end
            ST_TAIL0:
            begin
                if (status.rd_zero)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_off = OFF_TAIL1;
                    state_next = ST_TAIL1;
                end
                else
                begin
                    cmd.jp_clear = 1'b1;
                    state_next   = judge_exit;
                end
            end
            ST_TAIL1:
            begin
                if (status.rd_zero)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_off = OFF_TAIL2;
                    state_next = ST_TAIL2;
                end
                else
                begin
                    cmd.jp_clear = 1'b1;
                    state_next   = judge_exit;
                end
            end
            ST_TAIL2:
            begin
                cmd.seq_inc  = status.rd_low_only;
                cmd.jp_clear = 1'b1;
                state_next   = judge_exit;
            end
            ST_FLUSH:
            begin
                // Walk the remaining marks; each one found is judged on
                // the bytes that are actually left.
                if (status.avail_one)
                begin
                    state_next = ST_PROD;
                end
                else
                begin
                    cmd.flush_shift = 1'b1;
                    if (status.mark_next)
                    begin
                        state_next = ST_HDR;
                    end
                end
            end
            ST_PROD:
            begin
                cmd.prod_load = 1'b1;
                state_next    = ST_SCORE;
            end
            ST_SCORE:
            begin
                if (status.out_free)
                begin
                    cmd.score_load = 1'b1;
                    cmd.clear      = 1'b1;
                    flushing_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                flushing_next = 1'b0;
            end
        endcase
    end

    // State and registered flush flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            flushing_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            flushing_reg <= flushing_next;
        end
    end

endmodule

`default_nettype wire

[design/mpeg_video_start_code_prober_top.sv]
// Top level of the MPEG video start code prober.
// Depends on mvscp_pkg, mvscp_if, mvscp_ctrl and mvscp_datapath.
//
//   Channel   Direction  Payload                    Transaction
//   stream    sink       data_byte[7:0], last_byte  valid & ready
//   result    source     score[6:0]                 valid & ready
//   cfg       write      cfg_wdata[6:0]             cfg_we
//
// Bytes are taken without pause while the controller is idle. A byte that
// completes the 139-byte window behind a sequence header stalls intake while
// the header is judged through the single read port of the byte buffer RAM.
// The last byte is followed by a walk of the header mark line, judging each
// header still pending, and then the products and score states.
// Reset sets the base score to 50 and clears the stream state; no clearing
// pass is needed. The score waits in an output register; a stalled result
// holds back intake only after the next last byte.
`default_nettype none

module mpeg_video_start_code_prober_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [mvscp_pkg::SCORE_W-1:0] cfg_wdata,
    mvscp_byte_if.sink                         stream,
    mvscp_score_if.source                      result
);
    import mvscp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;

    assign stream.ready = in_ready;

    // Sequencing of intake, judging, flush and score.
    mvscp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_last  (stream.last_byte),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Stream state, byte buffer and score.
    mvscp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .data_byte    (stream.data_byte),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .result_score (result.score)
    );

endmodule

`default_nettype wire
